/* sv/bda_pkg.sv */
package bda_pkg;

  localparam int IN_W   = 11;
  localparam int TICK_W = 32;
  localparam int DEB_W  = 8;
  localparam int REP_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 1'd1;

  localparam logic [DEB_W-1:0] DEB_RESET = 8'd1;
  localparam logic [REP_W-1:0] REP_RESET = 16'd5;

  // Shared controls for the per-button cells
  typedef struct packed {
    logic             upd;
    logic [TICK_W-1:0] tick;
    logic [DEB_W-1:0]  deb;
  } bda_ctl_t;

endpackage

/* sv/bda_btn.sv */
module bda_btn
  import bda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  bda_ctl_t ctl,
  input  logic     cur,
  output logic     stable_nxt
);

  logic              stable_r;
  logic              cand_r;
  logic              cand_nxt;
  logic [TICK_W-1:0] time_r;
  logic [TICK_W-1:0] time_nxt;
  logic [TICK_W-1:0] dt;

  assign dt = ctl.tick - time_r;

  always_comb begin
    stable_nxt = stable_r;
    cand_nxt   = cand_r;
    time_nxt   = time_r;
    if (cur == stable_r) begin
      cand_nxt = stable_r;
    end else if (cand_r == stable_r) begin
      cand_nxt = cur;
      time_nxt = ctl.tick;
    end else if (dt > {{(TICK_W-DEB_W){1'b0}}, ctl.deb}) begin
      stable_nxt = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cand_r   <= 1'b0;
      time_r   <= '0;
    end else if (ctl.upd) begin
      stable_r <= stable_nxt;
      cand_r   <= cand_nxt;
      time_r   <= time_nxt;
    end
  end

endmodule

/* sv/bda_report.sv */
module bda_report
  import bda_pkg::*;
#(
  parameter int BUTTON_COUNT = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic [TICK_W-1:0]       tick,
  input  logic [BUTTON_COUNT-1:0] vec_nxt,
  input  logic [REP_W-1:0]        repeat_period,
  input  logic                    out_ready,
  output logic                    same_tick,
  output logic                    out_valid,
  output logic [IN_W-1:0]         out_reported_buttons,
  output logic                    out_is_repeat
);

  logic [BUTTON_COUNT-1:0] last_rep_r;
  logic [TICK_W-1:0]       last_tick_r;
  logic                    out_valid_r;
  logic [IN_W-1:0]         out_rep_r;
  logic [IN_W-1:0]         out_rep_nxt;
  logic                    out_rpt_r;
  logic [TICK_W-1:0]       since;
  logic                    unchanged;
  logic                    emit;

  assign same_tick = (tick == last_tick_r);
  assign since     = tick - last_tick_r;
  assign unchanged = (vec_nxt == last_rep_r);
  assign emit      = !same_tick &&
                     (!unchanged ||
                      ((vec_nxt != '0) &&
                       (since > {{(TICK_W-REP_W){1'b0}}, repeat_period})));

  // Only the low input-width bits of the vector go out
  for (genvar j = 0; j < IN_W; j++) begin : g_out
    if (j < BUTTON_COUNT) begin : g_on
      assign out_rep_nxt[j] = vec_nxt[j];
    end else begin : g_off
      assign out_rep_nxt[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_rep_r  <= '0;
      last_tick_r <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && emit) begin
        last_rep_r  <= vec_nxt;
        last_tick_r <= tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_rep_r <= out_rep_nxt;
      out_rpt_r <= unchanged;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_reported_buttons = out_rep_r;
  assign out_is_repeat        = out_rpt_r;

endmodule

/* sv/button_debounce_autorepeat.sv */
// An accepted item waits in the stage register until the output register has room;
// its report, if any, is then registered in the output register.
// Throughput: one item per cycle; the input stage only waits while a report
// sits unread in the output register.
// Reset (synchronous, active low): all button state and report history clear,
// debounce_ticks returns to 1 and repeat_period to 5.
module button_debounce_autorepeat
  import bda_pkg::*;
#(
  parameter int BUTTON_COUNT = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TICK_W-1:0]    in_tick_now,
  input  logic [IN_W-1:0]      in_pressed_now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IN_W-1:0]      out_reported_buttons,
  output logic                 out_is_repeat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [DEB_W-1:0]        deb_r;
  logic [REP_W-1:0]        rep_r;
  logic                    stg_valid_r;
  logic [TICK_W-1:0]       stg_tick_r;
  logic [IN_W-1:0]         stg_pressed_r;
  logic                    advance;
  logic                    same_tick;
  logic [BUTTON_COUNT-1:0] cur;
  logic [BUTTON_COUNT-1:0] vec_nxt;
  bda_ctl_t                ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEB_RESET;
      rep_r <= REP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: deb_r <= cfg_wdata[DEB_W-1:0];
        CFG_REPEAT:   rep_r <= cfg_wdata[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // Staged item is consumed once the output register has room
  assign advance  = stg_valid_r && (!out_valid || out_ready);
  assign in_ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_tick_r    <= in_tick_now;
      stg_pressed_r <= in_pressed_now;
    end
  end

  assign ctl.upd  = advance && !same_tick;
  assign ctl.tick = stg_tick_r;
  assign ctl.deb  = deb_r;

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    if (i < IN_W) begin : g_in
      assign cur[i] = stg_pressed_r[i];
    end else begin : g_rel
      assign cur[i] = 1'b0;
    end

    bda_btn u_btn (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cur        (cur[i]),
      .stable_nxt (vec_nxt[i])
    );
  end

  bda_report #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_report (
    .clk                  (clk),
    .rst_n                (rst_n),
    .advance              (advance),
    .tick                 (stg_tick_r),
    .vec_nxt              (vec_nxt),
    .repeat_period        (rep_r),
    .out_ready            (out_ready),
    .same_tick            (same_tick),
    .out_valid            (out_valid),
    .out_reported_buttons (out_reported_buttons),
    .out_is_repeat        (out_is_repeat)
  );

endmodule
